// ===== hdl/scle_pkg.sv =====
package scle_pkg;

   // Display geometry
   localparam int DIGITS         = 16;
   localparam int LEDS_PER_DIGIT = 188;
   localparam int SEGS_PER_DIGIT = 32;
   localparam int CAPACITY       = DIGITS * SEGS_PER_DIGIT;

   // Field widths
   localparam int COLOR_W = 8;
   localparam int INDEX_W = 12;
   localparam int SEG_W   = 10;
   localparam int DIGIT_W = 5;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 4;
   localparam int CAP_W   = SEG_W + 1;
   localparam int HUE_W   = 9;

   // Hue mapping constants
   localparam int HUE_SCALE  = 360;
   localparam int HUE_REGION = 60;
   localparam int RAMP_MUL   = 17;

   // Controller to datapath commands
   typedef struct packed {
      logic       accept;
      logic       hue_step;
      logic       base_step;
      logic       shade_step;
      logic [1:0] shade_chan;
      logic       emit_load;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic in_range;
      logic emit_last;
      logic rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic [COLOR_W-1:0] first;
      logic [COUNT_W-1:0] count;
   } seg_entry_type;

   // Segment layout: start LED and run length for each slot of a digit
   function automatic seg_entry_type seg_rom(input logic [SLOT_W-1:0] slot);
      seg_entry_type e;
      case (slot)
         5'd0:  e = '{8'd38,  4'd10};
         5'd1:  e = '{8'd31,  4'd7};
         5'd2:  e = '{8'd24,  4'd7};
         5'd3:  e = '{8'd14,  4'd10};
         5'd4:  e = '{8'd7,   4'd7};
         5'd5:  e = '{8'd0,   4'd7};
         5'd6:  e = '{8'd65,  4'd4};
         5'd7:  e = '{8'd86,  4'd4};
         5'd8:  e = '{8'd48,  4'd5};
         5'd9:  e = '{8'd53,  4'd6};
         5'd10: e = '{8'd59,  4'd6};
         5'd11: e = '{8'd69,  4'd6};
         5'd12: e = '{8'd75,  4'd6};
         5'd13: e = '{8'd81,  4'd5};
         5'd14: e = '{8'd94,  4'd2};
         5'd15: e = '{8'd90,  4'd2};
         5'd16: e = '{8'd92,  4'd2};
         5'd17: e = '{8'd110, 4'd10};
         5'd18: e = '{8'd120, 4'd7};
         5'd19: e = '{8'd127, 4'd7};
         5'd20: e = '{8'd134, 4'd10};
         5'd21: e = '{8'd96,  4'd7};
         5'd22: e = '{8'd103, 4'd7};
         5'd23: e = '{8'd156, 4'd4};
         5'd24: e = '{8'd177, 4'd4};
         5'd25: e = '{8'd160, 4'd5};
         5'd26: e = '{8'd165, 4'd6};
         5'd27: e = '{8'd171, 4'd6};
         5'd28: e = '{8'd150, 4'd6};
         5'd29: e = '{8'd144, 4'd6};
         5'd30: e = '{8'd181, 4'd5};
         default: e = '{8'd186, 4'd2};
      endcase
      return e;
   endfunction

endpackage

// ===== hdl/scle_ctrl.sv =====
module scle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  scle_pkg::dp_status_type status,
   output scle_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HUE   = 3'd1;
   localparam logic [2:0] ST_BASE  = 3'd2;
   localparam logic [2:0] ST_SHADE = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] chan_ff, chan_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Sequence one transaction: hue, base color, three shade passes, LED writes
   always_comb begin
      state_in       = state_ff;
      chan_in        = chan_ff;
      cmd            = '0;
      cmd.accept     = accept;
      cmd.shade_chan = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            chan_in = 2'd0;
            if (accept && status.in_range) state_in = ST_HUE;
         end
         ST_HUE: begin
            cmd.hue_step = 1'b1;
            state_in     = ST_BASE;
         end
         ST_BASE: begin
            cmd.base_step = 1'b1;
            state_in      = ST_SHADE;
         end
         ST_SHADE: begin
            cmd.shade_step = 1'b1;
            if (chan_ff == 2'd2) begin
               state_in = ST_EMIT;
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            cmd.emit_load = status.rsp_free;
            if (status.rsp_free && status.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

// ===== hdl/scle_datapath.sv =====
module scle_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  scle_pkg::ctrl_cmd_type  cmd,
   output scle_pkg::dp_status_type status,
   input  logic [15:0]            req_tdata,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int C_W = scle_pkg::COLOR_W;

   logic [scle_pkg::SEG_W-1:0]   counter_ff, counter_in;
   logic [scle_pkg::SEG_W-1:0]   seg;
   logic                         in_range;
   logic [C_W-1:0]               hue_ff, light_ff;
   logic [scle_pkg::DIGIT_W-1:0] digit_ff;
   logic [scle_pkg::SLOT_W-1:0]  slot_ff;
   logic [scle_pkg::HUE_W-1:0]   h_ff;
   logic [scle_pkg::INDEX_W-1:0] base_idx_ff;
   logic [scle_pkg::COUNT_W-1:0] count_ff, pos_ff;
   logic [C_W-1:0]               rgb_ff [3];
   logic                         rsp_valid_ff;
   logic [scle_pkg::INDEX_W-1:0] rsp_idx_ff;
   logic [C_W-1:0]               rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                         rsp_last_ff;

   logic [16:0]                  h_prod;
   logic [13:0]                  idx_sum;
   scle_pkg::seg_entry_type      entry;
   logic [2:0]                   region;
   logic [5:0]                   rem;
   logic [9:0]                   ramp_prod;
   logic [C_W-1:0]               ramp;
   logic [C_W-1:0]               base_r, base_g, base_b;
   logic [C_W-1:0]               chan_val, operand, shaded;
   logic [C_W-1:0]               scale;
   logic [15:0]                  shade_prod;
   logic                         dark;

   // Segment number for this transaction and capacity check
   assign seg      = req_tuser ? '0 : counter_ff;
   assign in_range = scle_pkg::CAP_W'(seg) < scle_pkg::CAP_W'(scle_pkg::CAPACITY);
   assign counter_in = in_range ? seg + scle_pkg::SEG_W'(1) : counter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (cmd.accept) begin
         counter_ff <= counter_in;
      end
   end

   // Latch the transaction
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hue_ff   <= req_tdata[7:0];
         light_ff <= req_tdata[15:8];
         digit_ff <= seg[scle_pkg::SEG_W-1:scle_pkg::SLOT_W];
         slot_ff  <= seg[scle_pkg::SLOT_W-1:0];
      end
   end

   // Hue onto 0..358 degrees, LED base index from digit and segment layout
   assign h_prod  = 17'(hue_ff) * 17'(scle_pkg::HUE_SCALE);
   assign entry   = scle_pkg::seg_rom(slot_ff);
   assign idx_sum = 14'(digit_ff) * 14'(scle_pkg::LEDS_PER_DIGIT) + 14'(entry.first);

   always_ff @(posedge clock) begin
      if (cmd.hue_step) begin
         h_ff        <= h_prod[16:8];
         base_idx_ff <= idx_sum[scle_pkg::INDEX_W-1:0];
         count_ff    <= entry.count;
      end
   end

   // Region by compare, ramp = rem*255/60 = rem*17/4
   always_comb begin
      if (h_ff < 9'd60) begin
         region = 3'd0; rem = 6'(h_ff);
      end else if (h_ff < 9'd120) begin
         region = 3'd1; rem = 6'(h_ff - 9'd60);
      end else if (h_ff < 9'd180) begin
         region = 3'd2; rem = 6'(h_ff - 9'd120);
      end else if (h_ff < 9'd240) begin
         region = 3'd3; rem = 6'(h_ff - 9'd180);
      end else if (h_ff < 9'd300) begin
         region = 3'd4; rem = 6'(h_ff - 9'd240);
      end else begin
         region = 3'd5; rem = 6'(h_ff - 9'd300);
      end
   end

   assign ramp_prod = 10'(rem) * 10'(scle_pkg::RAMP_MUL);
   assign ramp      = ramp_prod[9:2];

   always_comb begin
      case (region)
         3'd0:    begin base_r = 8'd255;        base_g = ramp;          base_b = 8'd0;          end
         3'd1:    begin base_r = 8'd255 - ramp; base_g = 8'd255;        base_b = 8'd0;          end
         3'd2:    begin base_r = 8'd0;          base_g = 8'd255;        base_b = ramp;          end
         3'd3:    begin base_r = 8'd0;          base_g = 8'd255 - ramp; base_b = 8'd255;        end
         3'd4:    begin base_r = ramp;          base_g = 8'd0;          base_b = 8'd255;        end
         default: begin base_r = 8'd255;        base_g = 8'd0;          base_b = 8'd255 - ramp; end
      endcase
   end

   // Shade one channel per cycle through a shared multiplier
   assign dark       = ~light_ff[7];
   assign scale      = {light_ff[6:0], 1'b0};
   assign chan_val   = rgb_ff[cmd.shade_chan];
   assign operand    = dark ? chan_val : 8'd255 - chan_val;
   assign shade_prod = 16'(operand) * 16'(scale);
   assign shaded     = dark ? shade_prod[15:8] : chan_val + shade_prod[15:8];

   always_ff @(posedge clock) begin
      if (cmd.base_step) begin
         rgb_ff[0] <= base_r;
         rgb_ff[1] <= base_g;
         rgb_ff[2] <= base_b;
      end else if (cmd.shade_step) begin
         rgb_ff[cmd.shade_chan] <= shaded;
      end
   end

   // Walk the LED run
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff <= '0;
      end else if (cmd.emit_load) begin
         pos_ff <= pos_ff + scle_pkg::COUNT_W'(1);
      end
   end

   assign status.in_range  = in_range;
   assign status.emit_last = (pos_ff + scle_pkg::COUNT_W'(1)) == count_ff;
   assign status.rsp_free  = ~rsp_valid_ff | rsp_tready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_idx_ff   <= base_idx_ff + scle_pkg::INDEX_W'(pos_ff);
         rsp_red_ff   <= rgb_ff[0];
         rsp_green_ff <= rgb_ff[1];
         rsp_blue_ff  <= rgb_ff[2];
         rsp_last_ff  <= status.emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_blue_ff, rsp_green_ff, rsp_red_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/segment_color_led_expander_core.sv =====
// Channel   Direction  Payload
// req       in         tdata[7:0] hue, tdata[15:8] lightness; tuser frame_start
// rsp       out        tdata[11:0] led_index, [19:12] red, [27:20] green,
//                      [35:28] blue, [39:36] zero; tlast run_last
//
// A segment takes color work (hue, base, three shades on one 8x8 multiplier),
// then one LED write per cycle while the output is not stalled, then idle.
// Runs hold 2 to 10 LEDs. A segment beyond capacity is taken with no writes.
// Synchronous reset clears the segment counter and the handshake state.
// The output register holds a stalled write; the next transaction is taken
// while the last write of a run is still waiting.
module segment_color_led_expander_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // hue, lightness
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // led_index, red, green, blue, pad
   output logic        rsp_tlast
);

   scle_pkg::ctrl_cmd_type  cmd;
   scle_pkg::dp_status_type status;

   // Sequencer
   scle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Color and LED index datapath
   scle_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/sv/segment_color_led_expander_core_test.sv =====
module segment_color_led_expander_core_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASE_PAIRS    = 48;
   localparam int PRINT_LIMIT    = 100;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_phase_type;

   typedef struct packed {
      logic                         frame_start;
      logic [scle_pkg::COLOR_W-1:0] lightness;
      logic [scle_pkg::COLOR_W-1:0] hue;
   } segment_pair_type;

   typedef struct packed {
      logic [scle_pkg::INDEX_W-1:0] led_index;
      logic [scle_pkg::COLOR_W-1:0] red;
      logic [scle_pkg::COLOR_W-1:0] green;
      logic [scle_pkg::COLOR_W-1:0] blue;
      logic                         run_last;
   } led_write_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // hue, lightness
   logic        req_tuser  = 1'b0; // frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // led_index, red, green, blue, pad
   logic        rsp_tlast;

   // Start LED and run length of each segment slot within a digit
   int seg_start [scle_pkg::SEGS_PER_DIGIT] = '{
      38, 31, 24, 14, 7, 0, 65, 86, 48, 53, 59, 69, 75, 81, 94, 90,
      92, 110, 120, 127, 134, 96, 103, 156, 177, 160, 165, 171, 150, 144, 181, 186
   };
   int seg_leds [scle_pkg::SEGS_PER_DIGIT] = '{
      10, 7, 7, 10, 7, 7, 4, 4, 5, 6, 6, 6, 6, 5, 2, 2,
      2, 10, 7, 7, 10, 7, 7, 4, 4, 5, 6, 6, 6, 6, 5, 2
   };

   segment_pair_type pending_pairs [$];
   led_write_type    expected_writes [$];
   logic [scle_pkg::SEG_W-1:0] next_segment = '0;

   int total_pairs      = 0;
   int pairs_accepted   = 0;
   int pairs_past_cap   = 0;
   int writes_checked   = 0;
   int max_index_seen   = 0;
   int error_count      = 0;
   int idle_cycles      = 0;

   segment_color_led_expander_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Print one mismatch line (up to a cap) and count it
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("write %0d: %s is %0d, expected %0d",
                                   writes_checked, name, got, want));
   endtask

   task automatic add_pair(input logic [7:0] hue, input logic [7:0] lightness,
                           input logic frame_start);
      pending_pairs.push_back('{frame_start, lightness, hue});
   endtask

   // Short frames of random colors, with an occasional stray restart
   task automatic add_random_frames(input int pair_budget);
      int         added;
      int         frame_len;
      int         k;
      logic [7:0] lightness;
      added = 0;
      while (added < pair_budget) begin
         frame_len = $urandom_range(1, 40);
         for (k = 0; k < frame_len; k++) begin
            case ($urandom_range(9))
               0: lightness = 8'd0;
               1: lightness = 8'd127;
               2: lightness = 8'd128;
               3: lightness = 8'd255;
               default: lightness = 8'($urandom_range(255));
            endcase
            add_pair(8'($urandom_range(255)), lightness,
                     k == 0 || $urandom_range(99) < 3);
            added++;
         end
      end
   endtask

   function automatic idle_phase_type current_phase();
      return idle_phase_type'((pairs_accepted / PHASE_PAIRS) % 4);
   endfunction

   // Compute the color of one segment and queue one LED write per LED of its run
   function automatic void predict_segment_writes(input segment_pair_type pair);
      int unsigned h;
      int unsigned ramp;
      int unsigned scale;
      int unsigned seg;
      int unsigned digit;
      int unsigned slot;
      int unsigned rgb [3];
      int          c;
      int          j;
      led_write_type w;
      if (pair.frame_start) next_segment = '0;
      seg = next_segment;
      if (seg >= scle_pkg::CAPACITY) begin
         pairs_past_cap++;
         return;
      end
      next_segment = next_segment + 1'b1;

      // Full-saturation base color from the six hue regions
      h    = (int'(pair.hue) * scle_pkg::HUE_SCALE) >> 8;
      ramp = (h % scle_pkg::HUE_REGION) * 255 / scle_pkg::HUE_REGION;
      case (h / scle_pkg::HUE_REGION)
         0: rgb = '{255, ramp, 0};
         1: rgb = '{255 - ramp, 255, 0};
         2: rgb = '{0, 255, ramp};
         3: rgb = '{0, 255 - ramp, 255};
         4: rgb = '{ramp, 0, 255};
         default: rgb = '{255, 0, 255 - ramp};
      endcase

      // Darken below mid lightness, blend toward white above it
      if (pair.lightness < 128) begin
         scale = 2 * int'(pair.lightness);
         for (c = 0; c < 3; c++) rgb[c] = (rgb[c] * scale) >> 8;
      end else begin
         scale = 2 * (int'(pair.lightness) - 128);
         for (c = 0; c < 3; c++) rgb[c] = rgb[c] + (((255 - rgb[c]) * scale) >> 8);
      end

      digit = seg / scle_pkg::SEGS_PER_DIGIT;
      slot  = seg % scle_pkg::SEGS_PER_DIGIT;
      for (j = 0; j < seg_leds[slot]; j++) begin
         w.led_index = scle_pkg::INDEX_W'(digit * scle_pkg::LEDS_PER_DIGIT
                                          + seg_start[slot] + j);
         w.red       = scle_pkg::COLOR_W'(rgb[0]);
         w.green     = scle_pkg::COLOR_W'(rgb[1]);
         w.blue      = scle_pkg::COLOR_W'(rgb[2]);
         w.run_last  = (j + 1 == seg_leds[slot]);
         expected_writes.push_back(w);
      end
   endfunction

   // Request driver: hold each transaction until taken, idle per phase
   always @(posedge clock) begin : req_driver
      segment_pair_type pair;
      idle_phase_type   phase;
      int               idle_pct;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pair = {req_tuser, req_tdata[15:8], req_tdata[7:0]};
            predict_segment_writes(pair);
            pairs_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            phase    = current_phase();
            idle_pct = (phase == IDLE_SENDER) ? 72 : (phase == IDLE_BOTH) ? 36 : 0;
            if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
               pair = pending_pairs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {pair.lightness, pair.hue};
               req_tuser  <= pair.frame_start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response backpressure per phase
   always @(posedge clock) begin : rsp_stall
      idle_phase_type phase;
      int             stall_pct;
      phase     = current_phase();
      stall_pct = (phase == IDLE_RECEIVER) ? 72 : (phase == IDLE_BOTH) ? 36 : 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Response monitor: compare each LED write with the oldest expected one
   always @(posedge clock) begin : rsp_monitor
      led_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("LED write to index %0d with nothing expected",
                                      rsp_tdata[11:0]));
         end else begin
            want = expected_writes.pop_front();
            check_field("led_index", rsp_tdata[11:0], want.led_index);
            check_field("red", rsp_tdata[19:12], want.red);
            check_field("green", rsp_tdata[27:20], want.green);
            check_field("blue", rsp_tdata[35:28], want.blue);
            check_field("run_last", rsp_tlast, want.run_last);
            check_field("pad", rsp_tdata[39:36], 0);
            if (want.led_index > max_index_seen) max_index_seen = want.led_index;
         end
         writes_checked++;
      end
   end

   // Count cycles without any transaction on either channel
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int  k;
      bit  timed_out;
      timed_out = 1'b0;

      // Hue region edges and lightness extremes, plus frame restarts
      add_pair(8'd0, 8'd128, 1'b1);
      add_pair(8'd42, 8'd128, 1'b0);
      add_pair(8'd43, 8'd128, 1'b0);
      add_pair(8'd85, 8'd128, 1'b0);
      add_pair(8'd128, 8'd128, 1'b0);
      add_pair(8'd170, 8'd128, 1'b0);
      add_pair(8'd213, 8'd128, 1'b0);
      add_pair(8'd255, 8'd128, 1'b0);
      add_pair(8'd0, 8'd0, 1'b0);
      add_pair(8'd255, 8'd255, 1'b0);
      add_pair(8'd42, 8'd127, 1'b0);
      add_pair(8'd43, 8'd129, 1'b0);
      add_pair(8'd86, 8'd1, 1'b0);
      add_pair(8'd171, 8'd254, 1'b0);
      add_pair(8'd200, 8'd64, 1'b0);
      add_pair(8'd100, 8'd192, 1'b0);
      add_pair(8'd30, 8'd128, 1'b1);
      add_pair(8'd60, 8'd128, 1'b0);
      add_pair(8'd0, 8'd255, 1'b1);
      add_pair(8'd255, 8'd0, 1'b1);

      add_random_frames(70);

      // One long frame that walks the first few digits
      add_pair(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
      for (k = 1; k < 100; k++)
         add_pair(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);

      add_random_frames(70);
      total_pairs = pending_pairs.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait for all pairs to be taken and all LED writes to arrive
      while (!timed_out && !(pairs_accepted == total_pairs && expected_writes.size() == 0))
      begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
      if (timed_out) begin
         report_mismatch($sformatf("no transaction for %0d cycles", WATCHDOG_LIMIT));
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
      if (expected_writes.size() != 0)
         report_mismatch($sformatf("%0d LED writes never arrived", expected_writes.size()));

      $display("Covered %0d segment pairs (%0d past capacity), %0d LED writes checked",
               pairs_accepted, pairs_past_cap, writes_checked);
      $display("Long frame reached LED index %0d; %0d mismatches",
               max_index_seen, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/scle_pkg.sv
hdl/scle_ctrl.sv
hdl/scle_datapath.sv
hdl/segment_color_led_expander_core.sv
tb/sv/segment_color_led_expander_core_test.sv
